// ===== rtl/core/tmse_pkg.sv =====
package tmse_pkg;

    // field widths of the item and result channels
    localparam int STATE_W    = 4;
    localparam int SYM_W      = 8;
    localparam int ACT_W      = 3;
    localparam int CELL_IDX_W = 10;
    localparam int STATUS_W   = 3;
    localparam int HEAD_W     = 10;
    localparam int LEN_W      = 11;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT = 2'd2;

    localparam logic [STATE_W-1:0] START_RESET  = 4'd0;
    localparam logic [STATE_W-1:0] ACCEPT_RESET = 4'd1;
    localparam logic [STATE_W-1:0] REJECT_RESET = 4'd2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STEP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NORULE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RUN    = 3'd5;

    // blank tape symbol, underscore
    localparam logic [SYM_W-1:0] BLANK_SYM = 8'h5F;

    // states reachable through a 4 bit state code
    localparam int RULE_MAX_STATES = 1 << STATE_W;

    localparam int NUM_STATES_DEF = 16;
    localparam int TAPE_CELLS_DEF = 1024;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [STATE_W-1:0]    state_id;
        logic [SYM_W-1:0]      symbol;
        logic [STATE_W-1:0]    nxt_state;
        logic [SYM_W-1:0]      wr_sym;
        logic                  move_right;
        logic [CELL_IDX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  machine_state;
        logic [HEAD_W-1:0]   head_position;
        logic [SYM_W-1:0]    cell_data;
        logic [LEN_W-1:0]    tape_length;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic sweep;
        logic in_load;
        logic dispatch;
        logic sym_rd;
        logic rule_rd;
        logic exec;
        logic grow;
        logic tape_rd;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic step_go;
        logic state_ok;
        logic need_grow;
    } t_stat;

endpackage

// ===== rtl/core/tmse_if.sv =====
interface tmse_in_if;
    import tmse_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmse_out_if;
    import tmse_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tmse_ctrl.sv =====
module tmse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tmse_pkg::t_stat i_stat,
    output tmse_pkg::t_cmd  o_cmd
);
    import tmse_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SYM_RD,
        S_RULE_RD,
        S_EXEC,
        S_GROW,
        S_TAPE_RD,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                n_state = i_stat.step_go ? S_SYM_RD : S_TAPE_RD;
            end
            S_SYM_RD: begin
                o_cmd.sym_rd = 1'b1;
                n_state      = S_RULE_RD;
            end
            S_RULE_RD: begin
                o_cmd.rule_rd = 1'b1;
                n_state = i_stat.state_ok ? S_EXEC : S_TAPE_RD;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.need_grow ? S_GROW : S_TAPE_RD;
            end
            S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state    = S_TAPE_RD;
            end
            S_TAPE_RD: begin
                o_cmd.tape_rd = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // an accepted item is decoded in the following cycle
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted item not dispatched");

    // tape growth only follows a rule execution
    a_grow_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GROW) |-> ($past(r_state) == S_EXEC))
        else $error("growth without executed rule");

    // a loaded result is shown and the engine is free again
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result load lost");

endmodule

// ===== rtl/core/tmse_dpath.sv =====
module tmse_dpath #(
    parameter int NUM_STATES = tmse_pkg::NUM_STATES_DEF,
    parameter int TAPE_CELLS = tmse_pkg::TAPE_CELLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tmse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  tmse_pkg::t_in_item               i_item,
    input  tmse_pkg::t_cmd                   i_cmd,
    output tmse_pkg::t_stat                  o_stat,
    output tmse_pkg::t_out_item              o_result
);
    import tmse_pkg::*;

    // rule store covers only the states a 4 bit code can name
    localparam int RULE_STATES = (NUM_STATES < RULE_MAX_STATES) ? NUM_STATES : RULE_MAX_STATES;
    localparam int SW          = $clog2(RULE_STATES);
    localparam int RULE_DEPTH  = RULE_STATES * (1 << SYM_W);
    localparam int RAW         = SW + SYM_W;
    localparam int NSW         = $clog2(NUM_STATES + 1);
    localparam int SCW         = (NSW > STATE_W) ? NSW : STATE_W;
    localparam int TAW         = $clog2(TAPE_CELLS);
    localparam int TPW         = TAW + 1;
    localparam int LW          = $clog2(TAPE_CELLS + 1);
    localparam int CW          = (LW > CELL_IDX_W) ? LW : CELL_IDX_W;

    typedef struct packed {
        logic               hit;
        logic [STATE_W-1:0] nxt_state;
        logic [SYM_W-1:0]   wr_sym;
        logic               move_right;
    } t_rule;

    logic [STATE_W-1:0]  r_start, r_accept, r_reject;
    logic [STATE_W-1:0]  r_pstate, n_pstate;
    logic [TAW-1:0]      r_base, n_base;
    logic [TAW-1:0]      r_head, n_head;
    logic [LW-1:0]       r_used, n_used;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [RAW-1:0]      r_sweep;
    t_in_item            r_item;
    t_out_item           r_out;

    t_rule               r_rule_mem [RULE_DEPTH];
    t_rule               r_rule_q;
    logic [SYM_W-1:0]    r_tape_mem [TAPE_CELLS];
    logic [SYM_W-1:0]    r_cell_q;

    logic                rule_we;
    logic [RAW-1:0]      rule_waddr, rule_raddr;
    t_rule               rule_wdata;
    logic                tape_we;
    logic [TAW-1:0]      tape_waddr, tape_raddr;
    logic [SYM_W-1:0]    tape_wdata;

    logic is_accept, is_reject, state_ok, sid_ok, tape_full;
    logic at_right, at_left, edge_hit, is_read, rd_blank;
    logic [SYM_W-1:0]    rd_data;

    // logical tape position to circular store address
    function automatic logic [TAW-1:0] phys(input logic [TAW-1:0] base,
                                            input logic [TAW-1:0] pos);
        logic [TPW-1:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= TPW'(TAPE_CELLS)) begin
            sum = sum - TPW'(TAPE_CELLS);
        end
        return sum[TAW-1:0];
    endfunction

    // condition flags
    assign is_accept = (r_pstate == r_accept);
    assign is_reject = (r_pstate == r_reject);
    assign state_ok  = (SCW'(r_pstate) < SCW'(NUM_STATES));
    assign sid_ok    = (SCW'(r_item.state_id) < SCW'(NUM_STATES));
    assign tape_full = (r_used == LW'(TAPE_CELLS));
    assign at_right  = ((LW'(r_head) + LW'(1)) >= r_used);
    assign at_left   = (r_head == '0);
    assign edge_hit  = r_rule_q.move_right ? at_right : at_left;
    assign is_read   = (r_item.action == ACT_READ);

    assign o_stat.sweep_last = (r_sweep == RAW'(RULE_DEPTH - 1));
    assign o_stat.step_go    = (r_item.action == ACT_STEP) && !is_accept && !is_reject;
    assign o_stat.state_ok   = state_ok;
    assign o_stat.need_grow  = r_rule_q.hit && edge_hit && !tape_full;

    // read addresses
    assign rule_raddr = {r_pstate[SW-1:0], r_cell_q};
    assign tape_raddr = (i_cmd.tape_rd && is_read) ?
                        phys(r_base, TAW'(r_item.cell_index)) : phys(r_base, r_head);

    // next machine state and memory writes
    always_comb begin
        n_pstate   = r_pstate;
        n_base     = r_base;
        n_head     = r_head;
        n_used     = r_used;
        n_status   = r_status;
        rule_we    = 1'b0;
        rule_waddr = r_sweep;
        rule_wdata = '0;
        tape_we    = 1'b0;
        tape_waddr = phys(r_base, r_head);
        tape_wdata = BLANK_SYM;

        if (i_cmd.sweep) begin
            rule_we = 1'b1;
        end

        if (i_cmd.dispatch) begin
            n_status = ST_DONE;
            case (r_item.action)
                ACT_LOAD: begin
                    if (sid_ok) begin
                        rule_we    = 1'b1;
                        rule_waddr = {r_item.state_id[SW-1:0], r_item.symbol};
                        rule_wdata = '{hit: 1'b1, nxt_state: r_item.nxt_state,
                                       wr_sym: r_item.wr_sym,
                                       move_right: r_item.move_right};
                    end
                end
                ACT_CLEAR: begin
                    n_base   = '0;
                    n_used   = '0;
                    n_head   = '0;
                    n_pstate = r_start;
                end
                ACT_APPEND: begin
                    if (tape_full) begin
                        n_status = ST_FULL;
                    end else begin
                        tape_we    = 1'b1;
                        tape_waddr = phys(r_base, TAW'(r_used));
                        tape_wdata = r_item.symbol;
                        n_used     = r_used + LW'(1);
                    end
                end
                ACT_STEP: begin
                    if (is_accept) begin
                        n_status = ST_ACCEPT;
                    end else if (is_reject) begin
                        n_status = ST_REJECT;
                    end else if (r_used == '0) begin
                        // empty tape starts as one blank cell
                        n_base     = '0;
                        tape_we    = 1'b1;
                        tape_waddr = '0;
                        tape_wdata = BLANK_SYM;
                        n_used     = LW'(1);
                        n_head     = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.rule_rd && !state_ok) begin
            n_pstate = r_reject;
            n_status = ST_NORULE;
        end

        // apply the looked up rule
        if (i_cmd.exec) begin
            if (!r_rule_q.hit) begin
                n_pstate = r_reject;
                n_status = ST_NORULE;
            end else begin
                tape_we    = 1'b1;
                tape_waddr = phys(r_base, r_head);
                tape_wdata = r_rule_q.wr_sym;
                n_pstate   = r_rule_q.nxt_state;
                n_status   = ST_RUN;
                if (edge_hit) begin
                    if (tape_full) begin
                        n_pstate = r_reject;
                        n_status = ST_FULL;
                    end
                end else if (r_rule_q.move_right) begin
                    n_head = r_head + TAW'(1);
                end else begin
                    n_head = r_head - TAW'(1);
                end
            end
        end

        // add a blank cell at the edge the head leaves
        if (i_cmd.grow) begin
            tape_we    = 1'b1;
            tape_wdata = BLANK_SYM;
            n_used     = r_used + LW'(1);
            if (r_rule_q.move_right) begin
                tape_waddr = phys(r_base, TAW'(r_used));
                n_head     = r_head + TAW'(1);
            end else begin
                n_base     = (r_base == '0) ? TAW'(TAPE_CELLS - 1) : (r_base - TAW'(1));
                tape_waddr = n_base;
                n_head     = '0;
            end
        end
    end

    // read back data, blank beyond the used tape
    assign rd_blank = is_read ? (CW'(r_item.cell_index) >= CW'(r_used))
                              : (LW'(r_head) >= r_used);
    assign rd_data  = rd_blank ? BLANK_SYM : r_cell_q;

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RESET;
            r_accept <= ACCEPT_RESET;
            r_reject <= REJECT_RESET;
            r_pstate <= START_RESET;
            r_base   <= '0;
            r_head   <= '0;
            r_used   <= '0;
            r_sweep  <= '0;
        end else begin
            r_pstate <= n_pstate;
            r_base   <= n_base;
            r_head   <= n_head;
            r_used   <= n_used;
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + RAW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START:  r_start  <= i_cfg_data;
                    CFG_ACCEPT: r_accept <= i_cfg_data;
                    CFG_REJECT: r_reject <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // item, status and result registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.in_load) begin
            r_item <= i_item;
        end
        if (i_cmd.out_load) begin
            r_out.status        <= r_status;
            r_out.machine_state <= r_pstate;
            r_out.head_position <= HEAD_W'(r_head);
            r_out.cell_data     <= rd_data;
            r_out.tape_length   <= LEN_W'(r_used);
        end
    end

    // rule memory
    always_ff @(posedge i_clk) begin
        if (rule_we) begin
            r_rule_mem[rule_waddr] <= rule_wdata;
        end
        if (i_cmd.rule_rd) begin
            r_rule_q <= r_rule_mem[rule_raddr];
        end
    end

    // tape memory
    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_waddr] <= tape_wdata;
        end
        if (i_cmd.sym_rd || i_cmd.tape_rd) begin
            r_cell_q <= r_tape_mem[tape_raddr];
        end
    end

    assign o_result = r_out;

    // tape never grows past its capacity
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LW'(TAPE_CELLS))
        else $error("tape length beyond capacity");

    // head stays on a used cell
    a_head_in_tape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) |-> (LW'(r_head) < r_used))
        else $error("head outside used tape");

    // empty tape keeps the head at the origin
    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_head == '0))
        else $error("head moved on empty tape");

endmodule

// ===== rtl/core/turing_machine_step_engine.sv =====
// sequence: load, clear, append, read, unused actions and halted steps pass dispatch,
//   tape read and finish; a running step passes dispatch, symbol read, rule read, execute,
//   grow when the tape grows, tape read and finish, and goes from rule read to tape read
//   when the state has no row; one item at a time, finish waits while a result is unaccepted
// reset: synchronous active low; afterwards a clearing pass over all min(NUM_STATES,16)*256
//   rule entries (4096 by default) wipes them, no item is taken meanwhile, config writes are taken
module turing_machine_step_engine #(
    parameter int NUM_STATES = tmse_pkg::NUM_STATES_DEF,
    parameter int TAPE_CELLS = tmse_pkg::TAPE_CELLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tmse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tmse_in_if.sink                         i_in,
    tmse_out_if.source                      o_out
);
    import tmse_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    tmse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // tape, rule store and machine registers
    tmse_dpath #(
        .NUM_STATES (NUM_STATES),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_out.data)
    );

endmodule
